@@ sv/sst_pkg.sv @@
// ----------------------------------------------------------------------------
// sst_pkg
// Shared types and defaults for the stock span block: controller states,
// controller-to-datapath commands and datapath status.
// ----------------------------------------------------------------------------
package sst_pkg;

    localparam int MAX_LEN_DEF     = 1024;
    localparam int VALUE_WIDTH_DEF = 32;
    localparam int SPAN_WIDTH      = 11;

    typedef enum logic [2:0] {
        S_IDLE  = 3'b001,
        S_CHECK = 3'b010,
        S_LOAD  = 3'b100
    } t_state;

    // commands from the controller to the datapath
    typedef struct packed {
        logic accept;    // latch the incoming sample, apply restart
        logic pop;       // drop the top entry, fetch the one below
        logic load_top;  // move fetched entry into the top registers
        logic push;      // push the sample and emit its span
        logic emit_ovf;  // emit an overflow result, state untouched
    } t_cmd;

    // status from the datapath to the controller
    typedef struct packed {
        logic full;      // sequence already holds MAX_LEN samples
        logic empty;     // stack has no entries
        logic deep;      // stack has two or more entries
        logic top_le;    // top value is not greater than the sample
        logic out_free;  // output register can take a result this cycle
    } t_status;

endpackage

@@ sv/sst_if.sv @@
// ----------------------------------------------------------------------------
// sst_if
// Valid/ready channels of the stock span block: sample input and span output.
// ----------------------------------------------------------------------------
interface sst_in_if
    import sst_pkg::*;
#(
    parameter int VALUE_WIDTH = VALUE_WIDTH_DEF
);
    logic                   valid;
    logic                   ready;
    logic [VALUE_WIDTH-1:0] value;
    logic                   restart;

    modport source (output valid, output value, output restart, input ready);
    modport sink   (input valid, input value, input restart, output ready);
endinterface

interface sst_out_if
    import sst_pkg::*;
;
    logic                  valid;
    logic                  ready;
    logic [SPAN_WIDTH-1:0] span;
    logic                  overflow;

    modport source (output valid, output span, output overflow, input ready);
    modport sink   (input valid, input span, input overflow, output ready);
endinterface

@@ sv/sst_ctrl.sv @@
// ----------------------------------------------------------------------------
// sst_ctrl
// Controller: accepts a sample, pops until the stack is empty or a greater top
// remains, then pushes; span or overflow result goes to the output register.
// ----------------------------------------------------------------------------
module sst_ctrl
    import sst_pkg::*;
(
    input  logic    i_clk,
    input  logic    i_rst_n,
    input  logic    i_in_valid,
    output logic    o_in_ready,
    input  t_status i_status,
    output t_cmd    o_cmd
);

    t_state r_state;
    t_state n_state;

    assign o_in_ready = (r_state == S_IDLE);

    always_comb begin
        n_state = r_state;
        o_cmd   = '0;
        case (r_state)
            S_IDLE: begin
                if (i_in_valid) begin
                    o_cmd.accept = 1'b1;
                    n_state      = S_CHECK;
                end
            end
            S_CHECK: begin
                if (i_status.full) begin
                    if (i_status.out_free) begin
                        o_cmd.emit_ovf = 1'b1;
                        n_state        = S_IDLE;
                    end
                end else if (!i_status.empty && i_status.top_le) begin
                    o_cmd.pop = 1'b1;
                    // the last entry needs no fetch from memory
                    if (i_status.deep) begin
                        n_state = S_LOAD;
                    end
                end else if (i_status.out_free) begin
                    o_cmd.push = 1'b1;
                    n_state    = S_IDLE;
                end
            end
            S_LOAD: begin
                o_cmd.load_top = 1'b1;
                n_state        = S_CHECK;
            end
            default: begin
                n_state = S_IDLE;
            end
        endcase
    end

    always_ff @(posedge i_clk) begin
        if (!i_rst_n) begin
            r_state <= S_IDLE;
        end else begin
            r_state <= n_state;
        end
    end

    a_load_then_check: assert property (@(posedge i_clk) disable iff (!i_rst_n)
        (r_state == S_LOAD) |=> (r_state == S_CHECK))
        else $error("fetch not followed by compare");

    a_accept_then_check: assert property (@(posedge i_clk) disable iff (!i_rst_n)
        (i_in_valid && o_in_ready) |=> (r_state == S_CHECK))
        else $error("accepted sample not processed");

    a_pop_not_empty: assert property (@(posedge i_clk) disable iff (!i_rst_n)
        o_cmd.pop |-> (!i_status.empty && !i_status.full))
        else $error("pop on empty stack or full sequence");

endmodule

@@ sv/sst_datapath.sv @@
// ----------------------------------------------------------------------------
// sst_datapath
// Stack storage with the top entry in registers and the rest in memory,
// position and depth counters, span arithmetic and the output register.
// ----------------------------------------------------------------------------
module sst_datapath
    import sst_pkg::*;
#(
    parameter int MAX_LEN     = MAX_LEN_DEF,
    parameter int VALUE_WIDTH = VALUE_WIDTH_DEF
)(
    input  logic                   i_clk,
    input  logic                   i_rst_n,
    input  t_cmd                   i_cmd,
    output t_status                o_status,
    input  logic [VALUE_WIDTH-1:0] i_in_value,
    input  logic                   i_in_restart,
    sst_out_if.source              o_out
);

    localparam int PW = $clog2(MAX_LEN);      // position / address bits
    localparam int CW = $clog2(MAX_LEN + 1);  // count bits, holds MAX_LEN
    localparam int EW = VALUE_WIDTH + PW;     // memory entry bits

    // entries below the top of stack
    logic [EW-1:0] mem [MAX_LEN];

    logic [VALUE_WIDTH-1:0] r_value;
    logic [VALUE_WIDTH-1:0] r_top_val;
    logic [PW-1:0]          r_top_pos;
    logic [CW-1:0]          r_count;
    logic [CW-1:0]          r_pos;
    logic [EW-1:0]          r_rd_data;
    logic                   r_out_valid;
    logic [SPAN_WIDTH-1:0]  r_span;
    logic                   r_ovf;

    logic [CW-1:0]          n_span_full;
    logic                   mem_we;
    logic                   mem_re;
    logic [PW-1:0]          wr_addr;
    logic [PW-1:0]          rd_addr;

    assign o_status.full     = (r_pos == CW'(MAX_LEN));
    assign o_status.empty    = (r_count == '0);
    assign o_status.deep     = (r_count > CW'(1));
    assign o_status.top_le   = ($signed(r_top_val) <= $signed(r_value));
    assign o_status.out_free = !r_out_valid || o_out.ready;

    // no earlier greater sample: span is position plus one
    assign n_span_full = o_status.empty ? (r_pos + CW'(1))
                                        : (r_pos - CW'(r_top_pos));

    assign mem_we  = i_cmd.push && !o_status.empty;
    assign mem_re  = i_cmd.pop && o_status.deep;
    assign wr_addr = PW'(r_count - CW'(1));
    assign rd_addr = PW'(r_count - CW'(2));

    always_ff @(posedge i_clk) begin
        if (mem_we) begin
            mem[wr_addr] <= {r_top_val, r_top_pos};
        end
        if (mem_re) begin
            r_rd_data <= mem[rd_addr];
        end
    end

    always_ff @(posedge i_clk) begin
        if (i_cmd.accept) begin
            r_value <= i_in_value;
        end
        if (i_cmd.load_top) begin
            {r_top_val, r_top_pos} <= r_rd_data;
        end else if (i_cmd.push) begin
            r_top_val <= r_value;
            r_top_pos <= PW'(r_pos);
        end
        if (i_cmd.push) begin
            r_span <= SPAN_WIDTH'(n_span_full);
            r_ovf  <= 1'b0;
        end else if (i_cmd.emit_ovf) begin
            r_span <= '0;
            r_ovf  <= 1'b1;
        end
    end

    always_ff @(posedge i_clk) begin
        if (!i_rst_n) begin
            r_count     <= '0;
            r_pos       <= '0;
            r_out_valid <= 1'b0;
        end else begin
            if (i_cmd.accept && i_in_restart) begin
                r_count <= '0;
                r_pos   <= '0;
            end else if (i_cmd.pop) begin
                r_count <= r_count - CW'(1);
            end else if (i_cmd.push) begin
                r_count <= r_count + CW'(1);
                r_pos   <= r_pos + CW'(1);
            end
            if (i_cmd.push || i_cmd.emit_ovf) begin
                r_out_valid <= 1'b1;
            end else if (o_out.ready) begin
                r_out_valid <= 1'b0;
            end
        end
    end

    assign o_out.valid    = r_out_valid;
    assign o_out.span     = r_span;
    assign o_out.overflow = r_ovf;

    a_depth_le_pos: assert property (@(posedge i_clk) disable iff (!i_rst_n)
        r_count <= r_pos)
        else $error("stack deeper than sequence");

    a_no_result_overwrite: assert property (@(posedge i_clk) disable iff (!i_rst_n)
        (i_cmd.push || i_cmd.emit_ovf) |-> (!r_out_valid || o_out.ready))
        else $error("pending result overwritten");

    a_pos_bounded: assert property (@(posedge i_clk) disable iff (!i_rst_n)
        r_pos <= CW'(MAX_LEN))
        else $error("position beyond maximum length");

endmodule

@@ sv/stock_span_monotonic_stack.sv @@
// ----------------------------------------------------------------------------
// stock_span_monotonic_stack
// Stock span over a stream of signed samples using a monotonic stack.
// ----------------------------------------------------------------------------
// Each accepted sample yields one result: the distance back to the nearest
// earlier strictly greater sample, or position plus one when there is none.
// A sample is accepted, then compared and pushed, after any pops: a popped
// entry that has another entry below it is followed by a fetch of the new
// top from a memory with a registered read, while popping the last entry
// needs no fetch. Every sample is popped at most once. Results sit in an
// output register, so the next sample is taken while a result waits. Restart
// clears the sequence before its own sample; once MAX_LEN samples are held,
// further samples get span 0 with overflow set and change nothing. No
// clearing pass after reset.
// ----------------------------------------------------------------------------
module stock_span_monotonic_stack
    import sst_pkg::*;
#(
    parameter int MAX_LEN     = MAX_LEN_DEF,
    parameter int VALUE_WIDTH = VALUE_WIDTH_DEF
)(
    input  logic      i_clk,
    input  logic      i_rst_n,
    sst_in_if.sink    i_in,
    sst_out_if.source o_out
);

    t_cmd    cmd;
    t_status status;

    sst_ctrl u_ctrl (
        .i_clk      (i_clk),
        .i_rst_n    (i_rst_n),
        .i_in_valid (i_in.valid),
        .o_in_ready (i_in.ready),
        .i_status   (status),
        .o_cmd      (cmd)
    );

    sst_datapath #(
        .MAX_LEN     (MAX_LEN),
        .VALUE_WIDTH (VALUE_WIDTH)
    ) u_datapath (
        .i_clk        (i_clk),
        .i_rst_n      (i_rst_n),
        .i_cmd        (cmd),
        .o_status     (status),
        .i_in_value   (i_in.value),
        .i_in_restart (i_in.restart),
        .o_out        (o_out)
    );

endmodule

@@ dv/tb_stock_span_monotonic_stack.sv @@
`timescale 1ns / 1ps
// ----------------------------------------------------------------------------
// tb_stock_span_monotonic_stack
// Self-checking bench for the stock span block: a span tracker keeps its own
// monotonic stack, predicts each span/overflow result and checks the output
// stream in order, under random idling on both channels and one long output
// hold-off.
// ----------------------------------------------------------------------------
module tb_stock_span_monotonic_stack;
    import sst_pkg::*;

    localparam int VW           = VALUE_WIDTH_DEF;
    localparam int SEQ_MAX      = MAX_LEN_DEF;
    localparam int POS_W        = $clog2(MAX_LEN_DEF);
    localparam int TOTAL_ITEMS  = 1950;
    localparam int CALM_ITEMS   = 150;
    localparam int LONG_HOLD    = 300;
    localparam int HOLD_AT      = 400;
    localparam int DRAIN_CYCLES = 20;

    typedef enum int {
        PAT_NOISE,
        PAT_NARROW,
        PAT_FALL,
        PAT_RISE,
        PAT_SAW
    } t_pattern;

    typedef struct packed {
        logic [SPAN_WIDTH-1:0] span;
        logic                  overflow;
    } t_span_res;

    class span_tracker;
        logic signed [VW-1:0] stk_val [SEQ_MAX];
        logic [POS_W-1:0]     stk_pos [SEQ_MAX];
        int                   depth;
        int                   seq_pos;
        t_span_res            pending_spans [$];
        int                   errors;
        int                   n_results;
        int                   n_ovf;
        int                   n_restarts;
        int                   max_depth;

        function new();
            depth      = 0;
            seq_pos    = 0;
            errors     = 0;
            n_results  = 0;
            n_ovf      = 0;
            n_restarts = 0;
            max_depth  = 0;
        endfunction

        // predict the result of one accepted sample
        function void note_sample(logic signed [VW-1:0] v, logic rst);
            t_span_res r;
            if (rst) begin
                depth   = 0;
                seq_pos = 0;
                n_restarts++;
            end
            if (seq_pos >= SEQ_MAX) begin
                r.span     = '0;
                r.overflow = 1'b1;
            end else begin
                // equal values are popped too, only a strictly greater one stops
                while (depth > 0 && stk_val[depth-1] <= v)
                    depth--;
                if (depth == 0)
                    r.span = SPAN_WIDTH'(seq_pos + 1);
                else
                    r.span = SPAN_WIDTH'(seq_pos - int'(stk_pos[depth-1]));
                r.overflow     = 1'b0;
                stk_val[depth] = v;
                stk_pos[depth] = POS_W'(seq_pos);
                depth++;
                seq_pos++;
                if (depth > max_depth)
                    max_depth = depth;
            end
            pending_spans.insert(pending_spans.size(), r);
        endfunction

        function void check_span(logic [SPAN_WIDTH-1:0] span, logic ovf);
            t_span_res exp_res;
            if (pending_spans.size() == 0) begin
                $error("unexpected transaction: span=%0d overflow=%0b", span, ovf);
                errors++;
                return;
            end
            exp_res = pending_spans.pop_front();
            n_results++;
            if (ovf === 1'b1)
                n_ovf++;
            if (span !== exp_res.span) begin
                $error("span mismatch: expected %0d, actual %0d", exp_res.span, span);
                errors++;
            end
            if (ovf !== exp_res.overflow) begin
                $error("overflow mismatch: expected %0b, actual %0b",
                       exp_res.overflow, ovf);
                errors++;
            end
        endfunction
    endclass

    logic i_clk;
    logic i_rst_n;
    bit   calm;
    int   n_sent;

    span_tracker sb = new();

    sst_in_if #(.VALUE_WIDTH(VW)) in_if ();
    sst_out_if                    out_if ();

    stock_span_monotonic_stack #(
        .MAX_LEN     (SEQ_MAX),
        .VALUE_WIDTH (VW)
    ) i_dut (
        .i_clk   (i_clk),
        .i_rst_n (i_rst_n),
        .i_in    (in_if),
        .o_out   (out_if)
    );

    always begin
        i_clk = 1'b1;
        #5;
        i_clk = 1'b0;
        #5;
    end

    // offer one sample, with an occasional idle burst ahead of it
    task automatic send_sample(input logic signed [VW-1:0] v, input logic rst);
        if (!calm && $urandom_range(0, 7) == 0) begin
            in_if.valid <= 1'b0;
            repeat ($urandom_range(1, 6)) @(posedge i_clk);
        end
        in_if.valid   <= 1'b1;
        in_if.value   <= v;
        in_if.restart <= rst;
        @(posedge i_clk);
        while (!in_if.ready)
            @(posedge i_clk);
        sb.note_sample(v, rst);
        n_sent++;
    endtask

    function automatic logic signed [VW-1:0] pick_value(input t_pattern pat,
                                                        inout logic signed [VW-1:0] trend);
        case (pat)
            PAT_NARROW: return VW'(int'($urandom_range(0, 6)) - 3);
            PAT_FALL: begin
                trend = trend - VW'($urandom_range(0, 4));
                return trend;
            end
            PAT_RISE: begin
                trend = trend + VW'($urandom_range(0, 4));
                return trend;
            end
            PAT_SAW: begin
                if ($urandom_range(0, 19) == 0)
                    trend = trend + VW'($urandom_range(100, 1000));
                else
                    trend = trend - VW'($urandom_range(0, 3));
                return trend;
            end
            default: return VW'($urandom);
        endcase
    endfunction

    task automatic run_random();
        logic signed [VW-1:0] trend;
        logic signed [VW-1:0] v;
        t_pattern             pat;
        int                   seq_len;
        bit                   long_run;
        bit                   long_done;
        long_done = 1'b0;
        while (n_sent < TOTAL_ITEMS) begin
            long_run = 1'b0;
            if (!long_done && n_sent >= 200) begin
                // fill the sequence, then run past its end
                long_run  = 1'b1;
                long_done = 1'b1;
                seq_len   = SEQ_MAX + $urandom_range(3, 10);
                pat       = PAT_FALL;
            end else begin
                seq_len = ($urandom_range(0, 5) == 0) ? $urandom_range(80, 200)
                                                      : $urandom_range(1, 40);
                pat     = t_pattern'($urandom_range(0, 4));
            end
            trend = VW'($urandom);
            for (int i = 0; i < seq_len && n_sent < TOTAL_ITEMS; i++) begin
                calm = (n_sent >= TOTAL_ITEMS - CALM_ITEMS);
                v    = pick_value(pat, trend);
                if (long_run && i == 700)
                    v = {1'b0, {(VW-1){1'b1}}};
                send_sample(v, i == 0 || (!long_run && $urandom_range(0, 39) == 0));
            end
        end
    endtask

    initial begin : result_sink
        int stall_left;
        bit held;
        stall_left = 0;
        held       = 1'b0;
        @(posedge i_clk);
        while (!i_rst_n)
            @(posedge i_clk);
        forever begin
            if (out_if.valid && out_if.ready)
                sb.check_span(out_if.span, out_if.overflow);
            if (!held && sb.n_results >= HOLD_AT) begin
                // long hold-off so the block backs up into its input
                held       = 1'b1;
                stall_left = LONG_HOLD;
            end else if (stall_left == 0 && !calm && $urandom_range(0, 7) == 0) begin
                stall_left = $urandom_range(1, 6);
            end
            if (stall_left > 0) begin
                out_if.ready <= 1'b0;
                stall_left--;
            end else begin
                out_if.ready <= 1'b1;
            end
            @(posedge i_clk);
        end
    end

    initial begin
        #3_000_000;
        $display("[stock_span_monotonic_stack] ERROR");
        $finish;
    end

    initial begin
        calm           = 1'b0;
        n_sent         = 0;
        i_rst_n       <= 1'b0;
        in_if.valid   <= 1'b0;
        in_if.value   <= '0;
        in_if.restart <= 1'b0;
        out_if.ready  <= 1'b0;
        repeat (7) @(posedge i_clk);
        i_rst_n <= 1'b1;
        @(posedge i_clk);

        // directed: extremes, equal values, restarts mid-sequence
        send_sample(32'sd0, 1'b1);
        send_sample(32'sh7FFF_FFFF, 1'b0);
        send_sample(32'sh8000_0000, 1'b0);
        send_sample(-32'sd1, 1'b0);
        send_sample(-32'sd1, 1'b0);
        send_sample(-32'sd1, 1'b0);
        send_sample(32'sd5, 1'b0);
        send_sample(32'sd5, 1'b0);
        send_sample(32'sh7FFF_FFFF, 1'b0);
        send_sample(32'sh8000_0000, 1'b0);
        send_sample(32'sd3, 1'b0);
        send_sample(32'sd100, 1'b1);
        send_sample(32'sd100, 1'b0);
        send_sample(32'sd50, 1'b0);
        send_sample(32'sd20, 1'b0);
        send_sample(32'sd20, 1'b0);
        send_sample(32'sd60, 1'b0);
        send_sample(32'sh8000_0000, 1'b0);
        send_sample(32'sh8000_0000, 1'b1);
        send_sample(32'sh8000_0000, 1'b0);
        send_sample(32'sh5555_5555, 1'b0);
        send_sample(32'shAAAA_AAAA, 1'b0);

        run_random();
        in_if.valid <= 1'b0;

        while (sb.pending_spans.size() != 0)
            @(posedge i_clk);
        repeat (DRAIN_CYCLES) @(posedge i_clk);

        $display("covered %0d samples, %0d restarts, %0d overflow results, deepest stack %0d",
                 n_sent, sb.n_restarts, sb.n_ovf, sb.max_depth);
        if (sb.errors == 0) begin
            $display("[stock_span_monotonic_stack] OK");
        end else begin
            $display("[stock_span_monotonic_stack] ERROR");
        end
        $finish;
    end

endmodule
